FILE: sv/cams2d_pkg.sv
// Shared types, register codes, reset values and fixed-point helpers for the 2-D motion step.
package cams2d_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SpanW = 31;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD_FRAC    = 3'd0,
    REG_HALF_PERIOD_SQ = 3'd1,
    REG_ROOM_LEFT      = 3'd2,
    REG_ROOM_BOTTOM    = 3'd3,
    REG_ROOM_SPAN_X    = 3'd4,
    REG_ROOM_SPAN_Y    = 3'd5,
    REG_SAMPLE_LIMIT   = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [DataW-1:0]        PeriodFracRst   = 32'd42949673;  // 100 Hz
  localparam logic [DataW-1:0]        HalfPeriodSqRst = 32'd214748;
  localparam logic signed [DataW-1:0] RoomLowRst      = 32'sd0;
  localparam logic [SpanW-1:0]        RoomSpanRst     = 31'd65536000;
  localparam logic [DataW-1:0]        SampleLimitRst  = 32'hFFFF_FFFF;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

  // Position and velocity of one axis
  typedef struct packed {
    logic signed [DataW-1:0] pos;
    logic signed [DataW-1:0] vel;
  } axis_t;

  // Signed Q16.16 times unsigned Q0.32, floored back to Q16.16
  function automatic logic signed [DataW-1:0] mul_q(input logic signed [DataW-1:0] a,
                                                     input logic [DataW-1:0] f);
    logic signed [2*DataW-1:0] p;
    p = 64'(a) * 64'($signed({1'b0, f}));
    return p[2*DataW-1:DataW];
  endfunction

  // Clamp a 34-bit signed sum to the signed 32-bit range
  function automatic logic signed [DataW-1:0] sat34(input logic signed [DataW+1:0] v);
    logic signed [DataW-1:0] r;
    if (v[DataW+1:DataW-1] == {3{v[DataW+1]}}) begin
      r = v[DataW-1:0];
    end else if (v[DataW+1]) begin
      r = SatMin;
    end else begin
      r = SatMax;
    end
    return r;
  endfunction

  // High room edge: low edge plus span, clamped
  function automatic logic signed [DataW-1:0] high_edge(input logic signed [DataW-1:0] low,
                                                        input logic [SpanW-1:0] span);
    return sat34(34'(low) + $signed({3'b000, span}));
  endfunction

  // One constant-acceleration step of one axis, with the room wrap on both edges
  function automatic axis_t move_axis(input axis_t cur,
                                      input logic signed [DataW-1:0] acc,
                                      input logic signed [DataW-1:0] low,
                                      input logic [SpanW-1:0] span,
                                      input logic [DataW-1:0] ts,
                                      input logic [DataW-1:0] hts);
    logic signed [DataW+1:0] np;
    logic signed [DataW-1:0] p;
    logic signed [DataW-1:0] high;
    axis_t nxt;
    np   = 34'(cur.pos) + 34'(mul_q(cur.vel, ts)) + 34'(mul_q(acc, hts));
    p    = sat34(np);
    high = high_edge(low, span);
    nxt.vel = sat34(34'(cur.vel) + 34'(mul_q(acc, ts)));
    if (p < low) begin
      p = high;
    end
    if (p > high) begin
      p = low;
    end
    nxt.pos = p;
    return nxt;
  endfunction

endpackage

FILE: sv/constant_accel_motion_step_2d.sv
// Top level of the two-axis constant-acceleration motion step.
//
// Usage:
//   Slave stream s_axis: one item per simulation tick, tdata carries the
//   random accelerations accel_x (bits 31:0) and accel_y (bits 63:32), Q16.16.
//   Master stream m_axis: one item per tick, tdata carries pos_x, pos_y,
//   vel_x, vel_y (32 bits each, lowest first), tuser carries finished.
//   cfg port: write register cfg_index with cfg_data; always ready. Write
//   only while no tick is in flight; unused indexes are ignored.
// Timing:
//   An accepted item lands in an input register; the motion update runs
//   combinationally from there into the result register. One item per cycle
//   is sustained while m_axis_tready stays high; the rate is set by the
//   combinational state loop (multiply, add, saturate, wrap).
// Reset (rst, synchronous): clear position, velocity and tick count to zero,
//   load register defaults (100 Hz period, 1000-unit room at the origin,
//   no sample limit), and empty both stages.
// Stall: when m_axis_tready is low the result holds, the input register
//   still takes one item, and s_axis_tready then drops until the result moves.
module constant_accel_motion_step_2d
  import cams2d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*DataW-1:0]   s_axis_tdata,   // accel_x, accel_y
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [4*DataW-1:0]   m_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
  output logic                 m_axis_tuser,   // finished
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [DataW-1:0]     cfg_data
);

  // configuration registers
  logic [DataW-1:0]        period_frac;
  logic [DataW-1:0]        half_period_sq;
  logic signed [DataW-1:0] room_left;
  logic signed [DataW-1:0] room_bottom;
  logic [SpanW-1:0]        room_span_x;
  logic [SpanW-1:0]        room_span_y;
  logic [DataW-1:0]        sample_limit;

  // motion state
  axis_t            x_state;
  axis_t            y_state;
  logic [DataW-1:0] tick_count;

  // input stage
  logic                    in_valid;
  logic signed [DataW-1:0] accel_x;
  logic signed [DataW-1:0] accel_y;

  // result stage
  logic                 out_valid;
  logic [4*DataW-1:0]   out_data;
  logic                 out_finished;

  logic  advance;    // input stage moves into the result register
  logic  move;       // this tick changes the state
  axis_t x_next;
  axis_t y_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_frac    <= PeriodFracRst;
      half_period_sq <= HalfPeriodSqRst;
      room_left      <= RoomLowRst;
      room_bottom    <= RoomLowRst;
      room_span_x    <= RoomSpanRst;
      room_span_y    <= RoomSpanRst;
      sample_limit   <= SampleLimitRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD_FRAC:    period_frac    <= cfg_data;
        REG_HALF_PERIOD_SQ: half_period_sq <= cfg_data;
        REG_ROOM_LEFT:      room_left      <= $signed(cfg_data);
        REG_ROOM_BOTTOM:    room_bottom    <= $signed(cfg_data);
        REG_ROOM_SPAN_X:    room_span_x    <= cfg_data[SpanW-1:0];
        REG_ROOM_SPAN_Y:    room_span_y    <= cfg_data[SpanW-1:0];
        REG_SAMPLE_LIMIT:   sample_limit   <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Two-stage flow: the input register empties whenever the result slot is free
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      accel_x <= $signed(s_axis_tdata[DataW-1:0]);
      accel_y <= $signed(s_axis_tdata[2*DataW-1:DataW]);
    end
  end

  // Motion update, straight from the current state and the held accelerations
  assign move   = tick_count < sample_limit;
  assign x_next = move_axis(x_state, accel_x, room_left, room_span_x,
                            period_frac, half_period_sq);
  assign y_next = move_axis(y_state, accel_y, room_bottom, room_span_y,
                            period_frac, half_period_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_state    <= '0;
      y_state    <= '0;
      tick_count <= '0;
    end else if (advance && move) begin
      x_state    <= x_next;
      y_state    <= y_next;
      tick_count <= tick_count + 32'd1;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (move) begin
        out_data <= {y_next.vel, x_next.vel, y_next.pos, x_next.pos};
      end else begin
        out_data <= {y_state.vel, x_state.vel, y_state.pos, x_state.pos};
      end
      out_finished <= !move;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_finished;

`ifndef SYNTHESIS
  // A finished tick leaves the motion state untouched
  assert property (@(posedge clk) disable iff (rst)
    advance && !move |=> $stable(x_state) && $stable(y_state) && $stable(tick_count))
    else $error("state changed on a finished tick");

  // A moving tick counts exactly once
  assert property (@(posedge clk) disable iff (rst)
    advance && move |=> tick_count == $past(tick_count) + 32'd1)
    else $error("tick count did not advance by one");

  // The wrapped position always lies within the room
  assert property (@(posedge clk) disable iff (rst)
    advance && move |->
      x_next.pos >= room_left && x_next.pos <= high_edge(room_left, room_span_x) &&
      y_next.pos >= room_bottom && y_next.pos <= high_edge(room_bottom, room_span_y))
    else $error("position outside the room after wrap");
`endif

endmodule
